FILE: src/gpcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpcr_pkg
// Shared types and constants of the grid polyline collinear reducer.
// ----------------------------------------------------------------------------
package gpcr_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

   localparam logic STATUS_KEPT   = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   localparam logic MODE_AXIAL    = 1'b0;
   localparam logic MODE_DIAGONAL = 1'b1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   // one result beat
   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      last;
      logic      status;
   } res_type;

   // results caused by one input point: one or two beats
   typedef struct packed {
      logic    two;
      res_type res0;
      res_type res1;
   } pair_type;

   // front to queue
   typedef struct packed {
      logic     push;
      pair_type data;
   } push_type;

endpackage

FILE: src/gpcr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpcr channel interfaces
// Point stream, result stream and register write channel.
// ----------------------------------------------------------------------------
interface gpcr_req_if;
   logic                valid;
   logic                ready;
   gpcr_pkg::coord_type point_x;
   gpcr_pkg::coord_type point_y;
   logic                last_point;

   modport source (output valid, output point_x, output point_y, output last_point,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input last_point,
                   output ready);
   modport monitor (input valid, input ready, input point_x, input point_y,
                    input last_point);
endinterface

interface gpcr_rsp_if;
   logic                valid;
   logic                ready;
   gpcr_pkg::coord_type out_x;
   gpcr_pkg::coord_type out_y;
   logic                out_last;
   logic                out_status;

   modport source (output valid, output out_x, output out_y, output out_last,
                   output out_status, input ready);
   modport sink   (input valid, input out_x, input out_y, input out_last,
                   input out_status, output ready);
   modport monitor (input valid, input ready, input out_x, input out_y,
                    input out_last, input out_status);
endinterface

interface gpcr_csr_if;
   logic valid;
   logic ready;
   logic data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
   modport monitor (input valid, input ready, input data);
endinterface

FILE: src/gpcr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpcr_front
// Accepts points, tracks anchor and pending corner, and emits the result
// beats of each point as one queue entry.
// ----------------------------------------------------------------------------
module gpcr_front (
   input  logic                clock,
   input  logic                reset,
   gpcr_req_if.sink            req_chan,
   gpcr_csr_if.sink            csr_chan,
   input  logic                q_full,
   output gpcr_pkg::push_type  q_push
);

   typedef enum logic [1:0] {
      CLS_HORIZ = 2'd0,
      CLS_VERT  = 2'd1,
      CLS_DIAG  = 2'd2,
      CLS_ANTI  = 2'd3
   } line_cls_type;

   localparam int W = gpcr_pkg::COORD_WIDTH;
   localparam int D = gpcr_pkg::DIFF_WIDTH;

   logic                mode_ff;
   gpcr_pkg::coord_type ax_ff, ay_ff, px_ff, py_ff;
   gpcr_pkg::coord_type ax_in, ay_in, px_in, py_in;
   logic                av_ff, av_in, pv_ff, pv_in;
   line_cls_type        pcls_ff, pcls_in;

   logic                accept;
   gpcr_pkg::coord_type x, y, rx, ry;
   logic                last;
   logic signed [D-1:0] dx, dy;
   logic signed [D:0]   dxe, dye;
   logic                regular, nonzero, corner;
   line_cls_type        cls;
   gpcr_pkg::push_type  push;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && !q_full;

   assign x    = req_chan.point_x;
   assign y    = req_chan.point_y;
   assign last = req_chan.last_point;

   assign rx  = pv_ff ? px_ff : ax_ff;
   assign ry  = pv_ff ? py_ff : ay_ff;
   assign dx  = $signed({x[W-1], x}) - $signed({rx[W-1], rx});
   assign dy  = $signed({y[W-1], y}) - $signed({ry[W-1], ry});
   assign dxe = {dx[D-1], dx};
   assign dye = {dy[D-1], dy};

   assign nonzero = (dx != '0) || (dy != '0);
   assign regular = (dx == '0) || (dy == '0) ||
                    ((mode_ff == gpcr_pkg::MODE_DIAGONAL) && ((dxe == dye) || (dxe == -dye)));

   always_comb begin
      if (dy == '0) begin
         cls = CLS_HORIZ;
      end else if (dx == '0) begin
         cls = CLS_VERT;
      end else if (dx[D-1] == dy[D-1]) begin
         cls = CLS_DIAG;
      end else begin
         cls = CLS_ANTI;
      end
   end

   always_comb begin
      ax_in   = ax_ff;
      ay_in   = ay_ff;
      px_in   = px_ff;
      py_in   = py_ff;
      av_in   = av_ff;
      pv_in   = pv_ff;
      pcls_in = pcls_ff;
      corner  = 1'b0;
      push    = '0;
      if (!av_ff) begin
         push.push      = 1'b1;
         push.data.res0 = '{x: x, y: y, last: last, status: gpcr_pkg::STATUS_KEPT};
         if (!last) begin
            ax_in = x;
            ay_in = y;
            av_in = 1'b1;
            pv_in = 1'b0;
         end
      end else if (!regular) begin
         push.push      = 1'b1;
         push.data.res0 = '{x: x, y: y, last: 1'b0, status: gpcr_pkg::STATUS_REJECT};
      end else begin
         if (nonzero) begin
            if (!pv_ff) begin
               px_in   = x;
               py_in   = y;
               pv_in   = 1'b1;
               pcls_in = cls;
            end else if (pcls_ff == cls) begin
               // same line: extend, or drop the pending point when the point returns onto the anchor
               if (x == ax_ff && y == ay_ff) begin
                  pv_in = 1'b0;
               end else begin
                  px_in = x;
                  py_in = y;
               end
            end else begin
               corner  = 1'b1;
               ax_in   = px_ff;
               ay_in   = py_ff;
               px_in   = x;
               py_in   = y;
               pcls_in = cls;
            end
         end
         push.data.res0 = '{x: px_ff, y: py_ff, last: 1'b0, status: gpcr_pkg::STATUS_KEPT};
         if (last) begin
            push.push = 1'b1;
            if (corner) begin
               push.data.two  = 1'b1;
               push.data.res1 = '{x: pv_in ? px_in : ax_in, y: pv_in ? py_in : ay_in,
                                  last: 1'b1, status: gpcr_pkg::STATUS_KEPT};
            end else begin
               push.data.res0 = '{x: pv_in ? px_in : ax_in, y: pv_in ? py_in : ay_in,
                                  last: 1'b1, status: gpcr_pkg::STATUS_KEPT};
            end
            av_in = 1'b0;
            pv_in = 1'b0;
         end else begin
            push.push = corner;
         end
      end
   end

   assign q_push = '{push: push.push && accept, data: push.data};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= gpcr_pkg::MODE_DIAGONAL;
         av_ff   <= 1'b0;
         pv_ff   <= 1'b0;
         ax_ff   <= '0;
         ay_ff   <= '0;
         px_ff   <= '0;
         py_ff   <= '0;
         pcls_ff <= CLS_HORIZ;
      end else begin
         if (csr_chan.valid) begin
            mode_ff <= csr_chan.data;
         end
         if (accept) begin
            av_ff   <= av_in;
            pv_ff   <= pv_in;
            ax_ff   <= ax_in;
            ay_ff   <= ay_in;
            px_ff   <= px_in;
            py_ff   <= py_in;
            pcls_ff <= pcls_in;
         end
      end
   end

endmodule

FILE: src/gpcr_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpcr_fifo
// Short queue of result pairs between front and back.
// ----------------------------------------------------------------------------
module gpcr_fifo (
   input  logic                clock,
   input  logic                reset,
   input  gpcr_pkg::push_type  q_push,
   output logic                q_full,
   input  logic                q_pop,
   output logic                q_empty,
   output gpcr_pkg::pair_type  q_head
);

   localparam int AW = gpcr_pkg::FIFO_AW;

   gpcr_pkg::pair_type   mem_ff [gpcr_pkg::FIFO_DEPTH];
   logic [AW-1:0]        wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]          cnt_ff, cnt_in;
   logic                 do_pop;

   assign q_full  = (cnt_ff == (AW+1)'(gpcr_pkg::FIFO_DEPTH));
   assign q_empty = (cnt_ff == '0);
   assign q_head  = mem_ff[rd_ff];
   assign do_pop  = q_pop && !q_empty;

   always_comb begin
      wr_in  = q_push.push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(q_push.push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (q_push.push) begin
         mem_ff[wr_ff] <= q_push.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

FILE: src/gpcr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpcr_back
// Splits queued result pairs into beats and drives the result register.
// ----------------------------------------------------------------------------
module gpcr_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  gpcr_pkg::pair_type  q_head,
   output logic                q_pop,
   gpcr_rsp_if.source          rsp_chan
);

   logic                rsp_valid_ff;
   gpcr_pkg::res_type   rsp_data_ff, rsp_data_in;
   logic                sub_ff, sub_in;
   logic                load;

   assign load        = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_data_in = sub_ff ? q_head.res1 : q_head.res0;
   // advance the queue once the final beat of the pair leaves
   assign q_pop       = load && !q_empty && (sub_ff || !q_head.two);
   assign sub_in      = (load && !q_empty) ? (!sub_ff && q_head.two) : sub_ff;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_x      = rsp_data_ff.x;
   assign rsp_chan.out_y      = rsp_data_ff.y;
   assign rsp_chan.out_last   = rsp_data_ff.last;
   assign rsp_chan.out_status = rsp_data_ff.status;

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sub_ff       <= 1'b0;
      end else begin
         sub_ff <= sub_in;
         if (load) begin
            rsp_valid_ff <= !q_empty;
         end
      end
   end

endmodule

FILE: src/grid_polyline_collinear_reducer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_polyline_collinear_reducer_core
// Keeps only the corner points of a grid polyline stream.
// ----------------------------------------------------------------------------
//  channel    dir   payload                              handshake
//  req_chan   in    point_x, point_y, last_point         valid/ready
//  rsp_chan   out   out_x, out_y, out_last, out_status   valid/ready
//  csr_chan   in    connectivity_mode (1 bit)            valid/ready
//
//  One point per cycle is accepted while the queue is not full; its state
//  update is a combinational compare against the stored anchor and pending
//  points in the front. Results leave one beat per cycle while the receiver
//  is ready; a corner found on the last point gives two beats. A point's
//  beats pass from the front through the queue into the result register.
//  Reset clears the polyline state and sets connectivity_mode to 1.
//  A stalled result side fills the four-entry queue, then req ready drops.
// ----------------------------------------------------------------------------
module grid_polyline_collinear_reducer_core (
   input  logic       clock,
   input  logic       reset,
   gpcr_req_if.sink   req_chan,
   gpcr_rsp_if.source rsp_chan,
   gpcr_csr_if.sink   csr_chan
);

   gpcr_pkg::push_type q_push;
   gpcr_pkg::pair_type q_head;
   logic               q_full, q_empty, q_pop;

   gpcr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .csr_chan (csr_chan),
      .q_full   (q_full),
      .q_push   (q_push)
   );

   gpcr_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_full  (q_full),
      .q_pop   (q_pop),
      .q_empty (q_empty),
      .q_head  (q_head)
   );

   gpcr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

FILE: src/gpcr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpcr_checker
// Port-level checks of the reducer's result channel.
// ----------------------------------------------------------------------------
module gpcr_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  gpcr_pkg::coord_type rsp_out_x,
   input  gpcr_pkg::coord_type rsp_out_y,
   input  logic                rsp_out_last,
   input  logic                rsp_out_status
);

   // hold a result until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_out_x) && $stable(rsp_out_y) &&
         $stable(rsp_out_last) && $stable(rsp_out_status))
      else $error("stalled result changed");

   a_reject_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_status == gpcr_pkg::STATUS_REJECT) |-> !rsp_out_last)
      else $error("rejected point carries last marker");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind grid_polyline_collinear_reducer_core gpcr_checker u_gpcr_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_out_x      (rsp_chan.out_x),
   .rsp_out_y      (rsp_chan.out_y),
   .rsp_out_last   (rsp_chan.out_last),
   .rsp_out_status (rsp_chan.out_status)
);

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the grid polyline collinear reducer. Points are
// pushed through the request channel while a local corner predictor builds
// the expected result beats. Each result beat is compared field by field
// with the oldest expected beat. Directed polylines cover the special cases,
// then random polylines run in both connectivity modes, with random idle
// gaps, stall stretches and one long result stall.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int HOLD_CYCLES = 300;

   logic clock;
   logic reset;

   gpcr_req_if req_if ();
   gpcr_rsp_if rsp_if ();
   gpcr_csr_if csr_if ();

   grid_polyline_collinear_reducer_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // corner predictor state
   logic              mode_q;
   int                anchor_xq;
   int                anchor_yq;
   int                pend_xq;
   int                pend_yq;
   bit                anchor_ok;
   bit                pend_ok;
   gpcr_pkg::res_type corner_q[$];

   int fail_count;
   bit steady;
   bit hold_rsp;

   int dir_dx [8] = '{1, 1, 0, -1, -1, -1, 0, 1};
   int dir_dy [8] = '{0, 1, 1, 1, 0, -1, -1, -1};

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #(10_000_000);
      $display("CHECK FAILED");
      $finish;
   end

   function automatic int idle_len();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int rand_coord();
      return $urandom_range(0, 65535) - 32768;
   endfunction

   // 0 horizontal, 1 vertical, 2 and 3 the two diagonals
   function automatic int line_class(int dx, int dy);
      if (dy == 0) return 0;
      if (dx == 0) return 1;
      return ((dx > 0) == (dy > 0)) ? 2 : 3;
   endfunction

   function automatic bit seg_ok(int dx, int dy);
      int ax;
      int ay;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      if (dx == 0 || dy == 0) return 1'b1;
      return (mode_q == gpcr_pkg::MODE_DIAGONAL) && (ax == ay);
   endfunction

   function automatic gpcr_pkg::res_type make_res(int x, int y, logic lst, logic st);
      gpcr_pkg::res_type r;
      r.x      = x[gpcr_pkg::COORD_WIDTH-1:0];
      r.y      = y[gpcr_pkg::COORD_WIDTH-1:0];
      r.last   = lst;
      r.status = st;
      return r;
   endfunction

   function automatic void queue_beat(gpcr_pkg::res_type r);
      corner_q.insert(corner_q.size(), r);
   endfunction

   task automatic predict_point(int x, int y, logic lst);
      int rx;
      int ry;
      int dx;
      int dy;
      if (!anchor_ok) begin
         queue_beat(make_res(x, y, lst, gpcr_pkg::STATUS_KEPT));
         if (!lst) begin
            anchor_xq = x;
            anchor_yq = y;
            anchor_ok = 1'b1;
            pend_ok   = 1'b0;
         end
         return;
      end
      rx = pend_ok ? pend_xq : anchor_xq;
      ry = pend_ok ? pend_yq : anchor_yq;
      dx = x - rx;
      dy = y - ry;
      if (!seg_ok(dx, dy)) begin
         queue_beat(make_res(x, y, 1'b0, gpcr_pkg::STATUS_REJECT));
         return;
      end
      if (dx != 0 || dy != 0) begin
         if (!pend_ok) begin
            pend_xq = x;
            pend_yq = y;
            pend_ok = 1'b1;
         end else if (line_class(pend_xq - anchor_xq, pend_yq - anchor_yq)
                      == line_class(dx, dy)) begin
            // back onto the anchor: drop the pending point
            if (x == anchor_xq && y == anchor_yq) begin
               pend_ok = 1'b0;
            end else begin
               pend_xq = x;
               pend_yq = y;
            end
         end else begin
            queue_beat(make_res(pend_xq, pend_yq, 1'b0, gpcr_pkg::STATUS_KEPT));
            anchor_xq = pend_xq;
            anchor_yq = pend_yq;
            pend_xq   = x;
            pend_yq   = y;
         end
      end
      if (lst) begin
         if (pend_ok)
            queue_beat(make_res(pend_xq, pend_yq, 1'b1, gpcr_pkg::STATUS_KEPT));
         else
            queue_beat(make_res(anchor_xq, anchor_yq, 1'b1, gpcr_pkg::STATUS_KEPT));
         anchor_ok = 1'b0;
         pend_ok   = 1'b0;
      end
   endtask

   // called at a falling edge; returns at a falling edge with valid still high
   task automatic send_point(int x, int y, logic lst);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.point_x    = x[gpcr_pkg::COORD_WIDTH-1:0];
      req_if.point_y    = y[gpcr_pkg::COORD_WIDTH-1:0];
      req_if.last_point = lst;
      req_if.valid      = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      predict_point(x, y, lst);
      @(negedge clock);
   endtask

   task automatic write_mode(logic m);
      req_if.valid = 1'b0;
      while (corner_q.size() != 0) @(negedge clock);
      // let the last point clear the front even when it gave no beat
      repeat (6) @(negedge clock);
      csr_if.data  = m;
      csr_if.valid = 1'b1;
      do @(posedge clock); while (!csr_if.ready);
      mode_q = m;
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   task automatic send_polyline(int npts, int noise_pct);
      int x;
      int y;
      int rx;
      int ry;
      int dir;
      int len;
      int k;
      int r;
      r = $urandom_range(0, 3);
      if (r == 0) begin
         x = rand_coord();
         y = rand_coord();
      end else if (r == 1) begin
         x = $urandom_range(0, 1) ? 32767 - $urandom_range(0, 3) : -32768 + $urandom_range(0, 3);
         y = $urandom_range(0, 1) ? 32767 - $urandom_range(0, 3) : -32768 + $urandom_range(0, 3);
      end else begin
         x = $urandom_range(0, 100) - 50;
         y = $urandom_range(0, 100) - 50;
      end
      send_point(x, y, npts == 1);
      dir = $urandom_range(0, 7);
      for (k = 1; k < npts; k++) begin
         rx = pend_ok ? pend_xq : anchor_xq;
         ry = pend_ok ? pend_yq : anchor_yq;
         r  = $urandom_range(0, 99);
         if (r < noise_pct) begin
            x = rand_coord();
            y = rand_coord();
         end else if (r < noise_pct + 5) begin
            x = rx;
            y = ry;
         end else if (r < noise_pct + 9) begin
            x = anchor_xq;
            y = anchor_yq;
         end else begin
            if ($urandom_range(0, 2) == 0) dir = $urandom_range(0, 7);
            // keep a few diagonals in axial mode so they get rejected
            if (mode_q == gpcr_pkg::MODE_AXIAL && (dir % 2) == 1 &&
                $urandom_range(0, 9) != 0)
               dir = dir - 1;
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 30000) : $urandom_range(1, 6);
            x = rx + dir_dx[dir] * len;
            y = ry + dir_dy[dir] * len;
            if (x > 32767 || x < -32768 || y > 32767 || y < -32768) begin
               dir = (dir + 4) % 8;
               x   = rx + dir_dx[dir];
               y   = ry + dir_dy[dir];
               if (x > 32767 || x < -32768 || y > 32767 || y < -32768) begin
                  x = rx;
                  y = ry;
               end
            end
         end
         send_point(x, y, k == npts - 1);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      gpcr_pkg::res_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (corner_q.size() == 0) begin
            $error("unexpected result beat x=%0d y=%0d last=%0b status=%0b",
                   $signed(rsp_if.out_x), $signed(rsp_if.out_y),
                   rsp_if.out_last, rsp_if.out_status);
            fail_count++;
         end else begin
            want = corner_q.pop_front();
            if (rsp_if.out_x !== want.x) begin
               $error("out_x: expected %0d, got %0d", $signed(want.x),
                      $signed(rsp_if.out_x));
               fail_count++;
            end
            if (rsp_if.out_y !== want.y) begin
               $error("out_y: expected %0d, got %0d", $signed(want.y),
                      $signed(rsp_if.out_y));
               fail_count++;
            end
            if (rsp_if.out_last !== want.last) begin
               $error("out_last: expected %0b, got %0b", want.last, rsp_if.out_last);
               fail_count++;
            end
            if (rsp_if.out_status !== want.status) begin
               $error("out_status: expected %0b, got %0b", want.status,
                      rsp_if.out_status);
               fail_count++;
            end
         end
      end
   end

   // result receiver: random stalls, plus one long hold on request
   initial begin
      int stall_left;
      stall_left   = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_if.ready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (stall_left > 0) begin
            rsp_if.ready = 1'b0;
            stall_left--;
         end else if (!steady && $urandom_range(0, 5) == 0) begin
            rsp_if.ready = 1'b0;
            stall_left   = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
                                                        : $urandom_range(9, 39);
         end else begin
            rsp_if.ready = 1'b1;
         end
      end
   end

   task automatic test_first_and_flush();
      send_point(10, -20, 1'b1);
      // repeated point, then flush with no pending point
      send_point(1, 1, 1'b0);
      send_point(1, 1, 1'b1);
   endtask

   task automatic test_line_merge();
      send_point(0, 0, 1'b0);
      send_point(0, 0, 1'b0);
      send_point(5, 0, 1'b0);
      send_point(9, 0, 1'b0);
      send_point(3, 0, 1'b0);
      send_point(0, 0, 1'b0);
      send_point(4, 4, 1'b0);
      send_point(7, 7, 1'b0);
      send_point(7, 2, 1'b0);
      send_point(9, 3, 1'b0);
      send_point(9, 3, 1'b1);
      send_point(12, 2, 1'b1);
   endtask

   task automatic test_extremes();
      send_point(-32768, -32768, 1'b0);
      send_point(32767, -32768, 1'b0);
      send_point(32767, 32767, 1'b0);
      send_point(-32768, -32768, 1'b0);
      send_point(32767, -32767, 1'b0);
      send_point(-32768, 32767, 1'b1);
   endtask

   task automatic test_axial_mode();
      write_mode(gpcr_pkg::MODE_AXIAL);
      send_point(0, 0, 1'b0);
      send_point(3, 3, 1'b0);
      send_point(0, 4, 1'b0);
      send_point(2, 4, 1'b0);
      // switch mode with the polyline still open
      write_mode(gpcr_pkg::MODE_DIAGONAL);
      send_point(5, 7, 1'b0);
      send_point(5, 7, 1'b1);
   endtask

   task automatic test_random(int items, logic m, bit no_idle);
      int sent;
      int n;
      write_mode(m);
      steady = no_idle;
      sent   = 0;
      while (sent < items) begin
         n = $urandom_range(1, 16);
         send_polyline(n, 8);
         sent += n;
      end
      steady = 1'b0;
   endtask

   task automatic test_backpressure();
      write_mode(gpcr_pkg::MODE_DIAGONAL);
      steady   = 1'b1;
      hold_rsp = 1'b1;
      send_polyline(30, 0);
      send_polyline(30, 0);
      steady = 1'b0;
   endtask

   task automatic finish_run();
      int waited;
      req_if.valid = 1'b0;
      waited       = 0;
      while (corner_q.size() != 0 && waited < 20000) begin
         @(negedge clock);
         waited++;
      end
      repeat (10) @(negedge clock);
      if (corner_q.size() != 0) begin
         $error("%0d expected result beats never arrived", corner_q.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   endtask

   initial begin
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.point_x    = '0;
      req_if.point_y    = '0;
      req_if.last_point = 1'b0;
      csr_if.valid      = 1'b0;
      csr_if.data       = 1'b0;
      fail_count        = 0;
      steady            = 1'b0;
      hold_rsp          = 1'b0;
      mode_q            = gpcr_pkg::MODE_DIAGONAL;
      anchor_xq         = 0;
      anchor_yq         = 0;
      pend_xq           = 0;
      pend_yq           = 0;
      anchor_ok         = 1'b0;
      pend_ok           = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_first_and_flush();
      test_line_merge();
      test_extremes();
      test_axial_mode();
      test_random(350, gpcr_pkg::MODE_DIAGONAL, 1'b0);
      test_random(250, gpcr_pkg::MODE_AXIAL, 1'b0);
      test_random(150, gpcr_pkg::MODE_DIAGONAL, 1'b1);
      test_random(150, gpcr_pkg::MODE_AXIAL, 1'b0);
      test_backpressure();
      test_random(100, gpcr_pkg::MODE_DIAGONAL, 1'b0);
      finish_run();
   end

endmodule

FILE: sim.f
src/gpcr_pkg.sv
src/gpcr_if.sv
src/gpcr_front.sv
src/gpcr_fifo.sv
src/gpcr_back.sv
src/grid_polyline_collinear_reducer_core.sv
src/gpcr_checker.sv
test/tb_top.sv
